/* rtl/core/interpolated_percentile_unit_defines.svh */
// Assertion macros used by the interpolated percentile unit back end.
`ifndef INTERPOLATED_PERCENTILE_UNIT_DEFINES_SVH
`define INTERPOLATED_PERCENTILE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IPU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ipu_pkg.sv */
// Package of shared types, constants and helpers for the percentile unit.
`timescale 1ns / 1ps
package ipu_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int SAMPLE_BITS = 32;
   localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
   localparam int COUNT_BITS  = ADDR_BITS + 1;

   localparam int DATA_BITS   = 32;
   localparam int FRAC_BITS   = 17;
   localparam int FBITS       = 16;
   localparam int RANK_BITS   = FRAC_BITS + ADDR_BITS;
   localparam int PROD_BITS   = FBITS + DATA_BITS;

   localparam logic [FRAC_BITS-1:0] FRACTION_ONE   = 17'h10000;
   localparam logic [FRAC_BITS-1:0] FRACTION_RESET = 17'h08000;

   // front-to-back request queue, power-of-two depth
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);

   typedef struct packed {
      logic                 valid;
      logic [DATA_BITS-1:0] key;
      logic                 last;
   } item_type;

   typedef struct packed {
      logic                  valid;
      logic [DATA_BITS-1:0]  value;
      logic [COUNT_BITS-1:0] sample_count;
      logic                  overflow;
   } res_type;

   // sign-extend the low SAMPLE_BITS bits (identity at 32 bits)
   function automatic logic [DATA_BITS-1:0] sample_key(input logic [DATA_BITS-1:0] raw);
      logic signed [DATA_BITS-1:0] shifted;
      shifted = $signed(raw << (DATA_BITS - SAMPLE_BITS));
      return shifted >>> (DATA_BITS - SAMPLE_BITS);
   endfunction

endpackage

/* rtl/core/ipu_front.sv */
// Front end: accepts requests, forms sort keys, queues them for the back end.
`timescale 1ns / 1ps
module ipu_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [ipu_pkg::DATA_BITS-1:0]  req_sample,
   input  logic                           req_last,
   output ipu_pkg::item_type              item,
   input  logic                           item_take
);

   logic [ipu_pkg::DATA_BITS-1:0] key_q  [ipu_pkg::QDEPTH];
   logic                          last_q [ipu_pkg::QDEPTH];

   logic [ipu_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ipu_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ipu_pkg::QPTR_BITS:0]   q_count_ff, q_count_in;
   logic                          push_fire, pop_fire;

   assign req_full  = (q_count_ff == (ipu_pkg::QPTR_BITS+1)'(ipu_pkg::QDEPTH));
   assign push_fire = req_push && !req_full;
   assign pop_fire  = item.valid && item_take;

   assign item.valid = (q_count_ff != '0);
   assign item.key   = key_q[rd_ptr_ff];
   assign item.last  = last_q[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = wr_ptr_ff + (push_fire ? 1'b1 : 1'b0);
      rd_ptr_in  = rd_ptr_ff + (pop_fire ? 1'b1 : 1'b0);
      q_count_in = q_count_ff;
      if (push_fire && !pop_fire) begin
         q_count_in = q_count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         q_count_in = q_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         key_q[wr_ptr_ff]  <= ipu_pkg::sample_key(req_sample);
         last_q[wr_ptr_ff] <= req_last;
      end
   end

endmodule

/* rtl/core/ipu_back.sv */
// Back end: sorted insertion into the sample store and percentile interpolation.
`timescale 1ns / 1ps
`include "interpolated_percentile_unit_defines.svh"
module ipu_back (
   input  logic                           clock,
   input  logic                           reset,
   input  ipu_pkg::item_type              item,
   output logic                           item_take,
   input  logic [ipu_pkg::FRAC_BITS-1:0]  fraction,
   output ipu_pkg::res_type               res,
   input  logic                           res_ready
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SHIFT  = 4'd1;
   localparam logic [3:0] ST_PLACE  = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_RANK   = 4'd4;
   localparam logic [3:0] ST_READK  = 4'd5;
   localparam logic [3:0] ST_READK1 = 4'd6;
   localparam logic [3:0] ST_MUL    = 4'd7;
   localparam logic [3:0] ST_ADD    = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   localparam logic [ipu_pkg::COUNT_BITS-1:0] COUNT_FULL =
      ipu_pkg::COUNT_BITS'(ipu_pkg::MAX_SAMPLES);

   logic signed [ipu_pkg::DATA_BITS-1:0] store_mem [ipu_pkg::MAX_SAMPLES];
   logic signed [ipu_pkg::DATA_BITS-1:0] rd_data_ff;

   logic                                  rd_en, wr_en;
   logic [ipu_pkg::ADDR_BITS-1:0]         rd_addr, wr_addr;
   logic signed [ipu_pkg::DATA_BITS-1:0]  wr_data;

   logic [3:0]                            state_ff, state_in;
   logic [ipu_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   logic                                  dropped_ff, dropped_in;
   logic signed [ipu_pkg::DATA_BITS-1:0]  key_ff, key_in;
   logic                                  last_ff, last_in;
   logic [ipu_pkg::ADDR_BITS-1:0]         ptr_ff, ptr_in;
   logic [ipu_pkg::RANK_BITS-1:0]         rank_ff, rank_in;
   logic signed [ipu_pkg::DATA_BITS-1:0]  base_ff, base_in;
   logic [ipu_pkg::DATA_BITS-1:0]         diff_ff, diff_in;
   logic [ipu_pkg::PROD_BITS-1:0]         prod_ff, prod_in;
   logic signed [ipu_pkg::DATA_BITS-1:0]  value_ff, value_in;

   logic [ipu_pkg::COUNT_BITS-1:0]        cnt_dec;
   logic [ipu_pkg::ADDR_BITS-1:0]         cnt_m1;
   logic [ipu_pkg::ADDR_BITS-1:0]         rank_k;
   logic [ipu_pkg::FBITS-1:0]             rank_f;

   assign cnt_dec = count_ff - ipu_pkg::COUNT_BITS'(1);
   assign cnt_m1  = cnt_dec[ipu_pkg::ADDR_BITS-1:0];
   assign rank_k  = rank_ff[ipu_pkg::FBITS +: ipu_pkg::ADDR_BITS];
   assign rank_f  = rank_ff[ipu_pkg::FBITS-1:0];

   assign res.valid        = (state_ff == ST_OUT);
   assign res.value        = value_ff;
   assign res.sample_count = count_ff;
   assign res.overflow     = dropped_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      key_in     = key_ff;
      last_in    = last_ff;
      ptr_in     = ptr_ff;
      rank_in    = rank_ff;
      base_in    = base_ff;
      diff_in    = diff_ff;
      prod_in    = prod_ff;
      value_in   = value_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = key_ff;
      item_take  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (item.valid) begin
               item_take = 1'b1;
               key_in    = $signed(item.key);
               last_in   = item.last;
               if (count_ff == COUNT_FULL) begin
                  dropped_in = 1'b1;
                  state_in   = ST_CHECK;
               end else if (count_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_data  = $signed(item.key);
                  count_in = count_ff + 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  // start the scan at the top entry
                  rd_en    = 1'b1;
                  rd_addr  = cnt_m1;
                  ptr_in   = cnt_m1;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // rd_data_ff holds entry ptr_ff
            wr_en   = 1'b1;
            wr_addr = ptr_ff + 1'b1;
            if (rd_data_ff > key_ff) begin
               wr_data = rd_data_ff;
               if (ptr_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff - 1'b1;
                  ptr_in  = ptr_ff - 1'b1;
               end
            end else begin
               wr_data  = key_ff;
               count_in = count_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            wr_data  = key_ff;
            count_in = count_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (last_ff) begin
               rank_in  = ipu_pkg::RANK_BITS'(fraction) * ipu_pkg::RANK_BITS'(cnt_m1);
               state_in = ST_RANK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RANK: begin
            rd_en    = 1'b1;
            rd_addr  = rank_k;
            state_in = ST_READK;
         end
         ST_READK: begin
            base_in = rd_data_ff;
            if ({1'b0, rank_k} + ipu_pkg::COUNT_BITS'(1) == count_ff) begin
               value_in = rd_data_ff;
               state_in = ST_OUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = rank_k + 1'b1;
               state_in = ST_READK1;
            end
         end
         ST_READK1: begin
            // sorted order keeps this below 2^32
            diff_in  = rd_data_ff - base_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = ipu_pkg::PROD_BITS'(rank_f) * ipu_pkg::PROD_BITS'(diff_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            value_in = base_ff + $signed(prod_ff[ipu_pkg::PROD_BITS-1:ipu_pkg::FBITS]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (res_ready) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      last_ff  <= last_in;
      ptr_ff   <= ptr_in;
      rank_ff  <= rank_in;
      base_ff  <= base_in;
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
   end

   // sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   `IPU_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_FULL, "count past capacity")
   `IPU_ASSERT_NEXT(a_drop_on_full, clock, reset, (state_ff == ST_IDLE) && item.valid && (count_ff == COUNT_FULL), dropped_ff, "full store did not flag drop")
   `IPU_ASSERT_IMPL(a_result_nonempty, clock, reset, res.valid, count_ff != '0, "result with empty store")
   `IPU_ASSERT_NEXT(a_place_grows, clock, reset, state_ff == ST_PLACE, count_ff == $past(count_ff) + 1'b1, "placement did not grow count")

endmodule

/* rtl/core/interpolated_percentile_unit.sv */
// Interpolated percentile unit: top level with config register and result register.
`timescale 1ns / 1ps
// Usage
//   Requests (req_): a signed Q16.16 sample with req_last, taken when req_push
//   is high and req_full is low; a four-deep queue sits in front. Each sample
//   is inserted in ascending order into a 1024-entry store. A request with
//   req_last set closes the set and yields one result.
//   Results (rsp_): while rsp_empty is low, rsp_value, rsp_sample_count and
//   rsp_overflow hold the oldest result; rsp_pop takes it.
//   Config (csr_): csr_fraction (Q1.16, 65536 = max sample) is written when
//   csr_valid and csr_ready are high; write only while the unit is idle.
// Sequence (one request at a time through the back end)
//   An insert moves each stored sample larger than the new one up a place,
//   then writes the new one; an empty store takes it at once, a full store
//   drops it. A closing request then interpolates between the entries at and
//   above the rank (only one at the top) before its result enters the register.
// Reset: clears queues, sample count and overflow flag; fraction returns to
//   32768 (median). Store contents are not cleared.
// Stall: a held result does not stop intake; the back end waits in its output
//   state while the result register is occupied, then the queue fills.
module interpolated_percentile_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [ipu_pkg::DATA_BITS-1:0]    req_sample,
   input  logic                             req_last,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [ipu_pkg::DATA_BITS-1:0]    rsp_value,
   output logic [ipu_pkg::COUNT_BITS-1:0]   rsp_sample_count,
   output logic                             rsp_overflow,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ipu_pkg::FRAC_BITS-1:0]    csr_fraction
);

   ipu_pkg::item_type                item;
   logic                             item_take;
   ipu_pkg::res_type                 res;
   logic                             res_ready;

   logic [ipu_pkg::FRAC_BITS-1:0]    fraction_ff, fraction_in;
   logic [ipu_pkg::FRAC_BITS-1:0]    frac_eff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ipu_pkg::DATA_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic [ipu_pkg::COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic                             rsp_ovf_ff, rsp_ovf_in;

   // config register always accepts
   assign csr_ready   = 1'b1;
   assign fraction_in = (csr_valid && csr_ready) ? csr_fraction : fraction_ff;
   // values above one select the maximum sample
   assign frac_eff    = (fraction_ff > ipu_pkg::FRACTION_ONE) ? ipu_pkg::FRACTION_ONE
                                                              : fraction_ff;

   // result register frees on pop
   assign res_ready = !rsp_valid_ff || rsp_pop;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (res.valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res.value;
         rsp_count_in = res.sample_count;
         rsp_ovf_in   = res.overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_ff  <= ipu_pkg::FRACTION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fraction_ff  <= fraction_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   ipu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_sample (req_sample),
      .req_last   (req_last),
      .item       (item),
      .item_take  (item_take)
   );

   ipu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .item_take (item_take),
      .fraction  (frac_eff),
      .res       (res),
      .res_ready (res_ready)
   );

endmodule
